>>> src/l2sw_pkg.sv
// ----------------------------------------------------------------------------
// l2sw_pkg
// Shared constants, codes and types of the learning switch table.
// ----------------------------------------------------------------------------
package l2sw_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int PORT_COUNT  = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int MAC_W       = 48;
    localparam int PORT_W      = 4;

    // stream word widths
    localparam int S_TDATA_W   = 152;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 16;

    // all-ones destination
    localparam logic [MAC_W-1:0] MAC_BCAST = {MAC_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_FRAME  = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_RSVD   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ACT_FLOOD   = 2'd0,
        ACT_FORWARD = 2'd1,
        ACT_NONE    = 2'd2
    } action_t;

    // write, invalidate and clear requests into the table
    typedef struct packed {
        logic              wr_en;
        logic [IDX_W-1:0]  wr_idx;
        logic [MAC_W-1:0]  wr_mac;
        logic [PORT_W-1:0] wr_port;
        logic              inv_en;
        logic [IDX_W-1:0]  inv_idx;
        logic              clr;
    } tbl_req_t;

    // one table entry as read back
    typedef struct packed {
        logic              valid;
        logic [MAC_W-1:0]  mac;
        logic [PORT_W-1:0] port;
    } tbl_entry_t;

endpackage

>>> src/l2sw_table.sv
// ----------------------------------------------------------------------------
// l2sw_table
// Station table: MAC and port memory with registered read, valid flags in
// flip-flops that reset and the clear command wipe at once.
// ----------------------------------------------------------------------------
module l2sw_table (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [l2sw_pkg::IDX_W-1:0]    rd_addr,
    input  l2sw_pkg::tbl_req_t            req,
    output l2sw_pkg::tbl_entry_t          rd_entry
);
    import l2sw_pkg::*;

    logic [MAC_W+PORT_W-1:0] mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]  valid_reg;
    logic [MAC_W+PORT_W-1:0] rd_data_reg;
    logic                    rd_valid_reg;

    // mac and port storage, one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_idx] <= {req.wr_mac, req.wr_port};
        end
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // entry valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (req.clr)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_idx] <= 1'b1;
            end
            if (req.inv_en)
            begin
                valid_reg[req.inv_idx] <= 1'b0;
            end
        end
    end

    assign rd_entry.valid = rd_valid_reg;
    assign rd_entry.mac   = rd_data_reg[MAC_W+PORT_W-1:PORT_W];
    assign rd_entry.port  = rd_data_reg[PORT_W-1:0];

endmodule

>>> src/l2_mac_learning_switch_unit.sv
// ----------------------------------------------------------------------------
// l2_mac_learning_switch_unit
// A frame or delete word scans every table entry once, one entry
// per cycle through the table memory read port, then its result word is
// registered once the output is free. No new word is taken before that result;
// clear and unknown commands skip the scan and go straight to the result.
// Reset: asynchronous, active low; all entries become invalid at once.
// ----------------------------------------------------------------------------
module l2_mac_learning_switch_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // src_mac[47:0], dst_mac[95:48], in_port[99:96], target_mac[147:100], zero
    input  logic [l2sw_pkg::S_TDATA_W-1:0]    s_tdata,
    // cmd[1:0]
    input  logic [l2sw_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // action[1:0], out_port[5:2], learned[6], learn_dropped[7],
    // delete_hit[8], zero
    output logic [l2sw_pkg::M_TDATA_W-1:0]    m_tdata
);
    import l2sw_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    state_t             state_reg, state_next;
    logic [1:0]         cmd_reg;
    logic [MAC_W-1:0]   key_reg;
    logic [MAC_W-1:0]   src_reg;
    logic [MAC_W-1:0]   dst_reg;
    logic [PORT_W-1:0]  port_reg;

    logic               issue_reg;
    logic [IDX_W-1:0]   rd_addr_reg;
    logic               cmp_vld_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;

    logic               key_hit_reg;
    logic [IDX_W-1:0]   key_idx_reg;
    logic               free_vld_reg;
    logic [IDX_W-1:0]   free_idx_reg;
    logic               dst_hit_reg;
    logic [PORT_W-1:0]  dst_port_reg;

    logic               m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic               s_fire;
    logic               finish_fire;
    logic               rd_en;
    tbl_req_t           tbl_req;
    tbl_entry_t         rd_entry;

    logic               key_match;
    logic               dst_match;
    logic               do_learn;
    logic               fwd_vld;
    logic [PORT_W-1:0]  fwd_port;
    logic [1:0]         res_action;
    logic [PORT_W-1:0]  res_port;
    logic               res_learned;
    logic               res_dropped;
    logic               res_dhit;

    assign s_tready    = (state_reg == ST_IDLE);
    assign s_fire      = s_tvalid && s_tready;
    assign finish_fire = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);
    assign rd_en       = (state_reg == ST_SCAN) && issue_reg;

    l2sw_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr_reg),
        .req      (tbl_req),
        .rd_entry (rd_entry)
    );

    // control state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    if (s_tuser == CMD_FRAME || s_tuser == CMD_DELETE)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN:
            begin
                if (cmp_vld_reg && cmp_idx_reg == LAST_IDX)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (finish_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            issue_reg    <= 1'b0;
            cmp_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cmp_vld_reg <= rd_en;
            if (s_fire)
            begin
                issue_reg <= 1'b1;
            end
            else if (rd_en && rd_addr_reg == LAST_IDX)
            begin
                issue_reg <= 1'b0;
            end
            if (finish_fire)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // command capture and scan address
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            cmd_reg     <= s_tuser;
            src_reg     <= s_tdata[47:0];
            dst_reg     <= s_tdata[95:48];
            port_reg    <= s_tdata[99:96];
            key_reg     <= (s_tuser == CMD_DELETE) ? s_tdata[147:100] : s_tdata[47:0];
            rd_addr_reg <= '0;
        end
        else if (rd_en)
        begin
            rd_addr_reg <= rd_addr_reg + 1'b1;
        end
        cmp_idx_reg <= rd_addr_reg;
    end

    // compare stage on the entry read back
    assign key_match = rd_entry.valid && (rd_entry.mac == key_reg);
    assign dst_match = rd_entry.valid && (rd_entry.mac == dst_reg);

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            key_hit_reg  <= 1'b0;
            free_vld_reg <= 1'b0;
            dst_hit_reg  <= 1'b0;
        end
        else if (cmp_vld_reg)
        begin
            if (key_match && !key_hit_reg)
            begin
                key_hit_reg <= 1'b1;
                key_idx_reg <= cmp_idx_reg;
            end
            if (!rd_entry.valid && !free_vld_reg)
            begin
                free_vld_reg <= 1'b1;
                free_idx_reg <= cmp_idx_reg;
            end
            if (dst_match && !dst_hit_reg)
            begin
                dst_hit_reg  <= 1'b1;
                dst_port_reg <= rd_entry.port;
            end
        end
    end

    // result and table update
    always_comb
    begin
        do_learn    = 1'b0;
        fwd_vld     = 1'b0;
        fwd_port    = '0;
        res_action  = ACT_NONE;
        res_port    = '0;
        res_learned = 1'b0;
        res_dropped = 1'b0;
        res_dhit    = 1'b0;
        case (cmd_reg)
            CMD_FRAME:
            begin
                do_learn    = !key_hit_reg && free_vld_reg;
                res_learned = do_learn;
                res_dropped = !key_hit_reg && !free_vld_reg;
                // a freshly learned source also answers its own destination
                if (dst_hit_reg)
                begin
                    fwd_vld  = 1'b1;
                    fwd_port = dst_port_reg;
                end
                else if (do_learn && dst_reg == src_reg)
                begin
                    fwd_vld  = 1'b1;
                    fwd_port = port_reg;
                end
                if (dst_reg == MAC_BCAST || !fwd_vld)
                begin
                    res_action = ACT_FLOOD;
                end
                else if (32'(fwd_port) < PORT_COUNT)
                begin
                    res_action = ACT_FORWARD;
                    res_port   = fwd_port;
                end
                else
                begin
                    res_action = ACT_NONE;
                end
            end
            CMD_DELETE:
            begin
                res_dhit = key_hit_reg;
            end
            default:
            begin
                res_action = ACT_NONE;
            end
        endcase
    end

    always_comb
    begin
        tbl_req.wr_en   = finish_fire && do_learn;
        tbl_req.wr_idx  = free_idx_reg;
        tbl_req.wr_mac  = src_reg;
        tbl_req.wr_port = port_reg;
        tbl_req.inv_en  = finish_fire && (cmd_reg == CMD_DELETE) && key_hit_reg;
        tbl_req.inv_idx = key_idx_reg;
        tbl_req.clr     = finish_fire && (cmd_reg == CMD_CLEAR);
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if (finish_fire)
        begin
            m_tdata_reg <= {7'd0, res_dhit, res_dropped, res_learned, res_port, res_action};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef NO_ASSERTIONS
    // one word at a time: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> !s_tready)
        else $error("input accepted while a word is in progress");

    // the table is not modified while it is being scanned
    a_no_update_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (!tbl_req.wr_en && !tbl_req.inv_en && !tbl_req.clr))
        else $error("table update during scan");

    // learn and drop never flagged together
    a_learn_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[6] && m_tdata[7]))
        else $error("learned and learn_dropped both set");

    // egress port only on forward, delete hit only with no forwarding
    a_port_on_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[1:0] != ACT_FORWARD) |-> (m_tdata[5:2] == '0))
        else $error("out_port set without forward");

    a_dhit_none: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[8]) |-> (m_tdata[1:0] == ACT_NONE))
        else $error("delete hit with forwarding action");
`endif

endmodule

>>> test/l2_mac_learning_switch_unit_tb.sv
// ----------------------------------------------------------------------------
// l2_mac_learning_switch_unit_tb
// Self-checking bench for the learning switch table. A behavioral copy of the
// station table predicts the decision word for every accepted command word.
// Decision words are compared field by field in order. Stimulus is a short
// directed run, then random frames, deletes, clears and reserved commands over
// a pool of related MAC addresses under several idle and stall mixes.
// ----------------------------------------------------------------------------
module l2_mac_learning_switch_unit_tb;

    import l2sw_pkg::*;

    localparam int          CLK_HALF     = 5;
    localparam int unsigned CYCLE_LIMIT  = 2_000_000;
    localparam int          HOLD_CYCLES  = 700;
    localparam int          PHASE_WORDS  = 460;
    localparam int          POOL_SIZE    = 96;
    localparam int          DRAIN_CYCLES = 2 * TABLE_DEPTH + 8;

    // expected decision for one command word
    typedef struct {
        action_t           action;
        logic [PORT_W-1:0] out_port;
        logic              learned;
        logic              learn_dropped;
        logic              delete_hit;
    } decision_t;

    // station table copy and queue of pending decisions
    class mac_table_model;
        bit                station_valid [TABLE_DEPTH];
        logic [MAC_W-1:0]  station_mac   [TABLE_DEPTH];
        logic [PORT_W-1:0] station_port  [TABLE_DEPTH];
        decision_t         expected_decisions[$];
        int                mismatch_count;

        function new();
            foreach (station_valid[i])
            begin
                station_valid[i] = 1'b0;
            end
            mismatch_count = 0;
        endfunction

        function int lookup(logic [MAC_W-1:0] mac);
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                if (station_valid[i] && station_mac[i] == mac)
                    return i;
            end
            return -1;
        endfunction

        function int lowest_free();
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                if (!station_valid[i])
                    return i;
            end
            return -1;
        endfunction

        function int pending();
            return expected_decisions.size();
        endfunction

        // predict the decision of one accepted command word
        function void note_word(cmd_t cmd, logic [MAC_W-1:0] src, logic [MAC_W-1:0] dst,
                                logic [PORT_W-1:0] in_port, logic [MAC_W-1:0] target);
            decision_t d;
            int        slot;
            d.action        = ACT_NONE;
            d.out_port      = '0;
            d.learned       = 1'b0;
            d.learn_dropped = 1'b0;
            d.delete_hit    = 1'b0;
            case (cmd)
                CMD_FRAME:
                begin
                    // learn the source first
                    if (lookup(src) < 0)
                    begin
                        slot = lowest_free();
                        if (slot >= 0)
                        begin
                            station_valid[slot] = 1'b1;
                            station_mac[slot]   = src;
                            station_port[slot]  = in_port;
                            d.learned           = 1'b1;
                        end
                        else
                            d.learn_dropped = 1'b1;
                    end
                    // then forward or flood
                    if (dst == MAC_BCAST)
                        d.action = ACT_FLOOD;
                    else
                    begin
                        slot = lookup(dst);
                        if (slot < 0)
                            d.action = ACT_FLOOD;
                        else if (int'(station_port[slot]) < PORT_COUNT)
                        begin
                            d.action   = ACT_FORWARD;
                            d.out_port = station_port[slot];
                        end
                    end
                end
                CMD_DELETE:
                begin
                    slot = lookup(target);
                    if (slot >= 0)
                    begin
                        station_valid[slot] = 1'b0;
                        d.delete_hit        = 1'b1;
                    end
                end
                CMD_CLEAR:
                begin
                    foreach (station_valid[i])
                    begin
                        station_valid[i] = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
            expected_decisions.push_back(d);
        endfunction

        // compare one accepted decision word with the oldest expectation
        function void check_word(logic [M_TDATA_W-1:0] w);
            decision_t d;
            if (expected_decisions.size() == 0)
            begin
                $error("decision word %h with nothing expected", w);
                mismatch_count++;
                return;
            end
            d = expected_decisions.pop_front();
            if (w[1:0] !== d.action)
            begin
                $error("action: expected %0d, got %0d", d.action, w[1:0]);
                mismatch_count++;
            end
            if (w[5:2] !== d.out_port)
            begin
                $error("out_port: expected %0d, got %0d", d.out_port, w[5:2]);
                mismatch_count++;
            end
            if (w[6] !== d.learned)
            begin
                $error("learned: expected %0d, got %0d", d.learned, w[6]);
                mismatch_count++;
            end
            if (w[7] !== d.learn_dropped)
            begin
                $error("learn_dropped: expected %0d, got %0d", d.learn_dropped, w[7]);
                mismatch_count++;
            end
            if (w[8] !== d.delete_hit)
            begin
                $error("delete_hit: expected %0d, got %0d", d.delete_hit, w[8]);
                mismatch_count++;
            end
            if (w[M_TDATA_W-1:9] !== '0)
            begin
                $error("padding: expected 0, got %h", w[M_TDATA_W-1:9]);
                mismatch_count++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    mac_table_model   table_model = new();
    int               send_idle_pct;
    int               recv_stall_pct;
    bit               hold_req;
    int unsigned      cycle_count;
    logic [MAC_W-1:0] mac_pool[POOL_SIZE];

    l2_mac_learning_switch_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // run limit
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // accepted command words feed the predictor
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            table_model.note_word(cmd_t'(s_tuser), s_tdata[47:0], s_tdata[95:48],
                                  s_tdata[99:96], s_tdata[147:100]);
    end

    // accepted decision words are checked
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            table_model.check_word(m_tdata);
    end

    // receiver: random stalls, or a long hold-off on request
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    function automatic logic [MAC_W-1:0] rand_mac();
        return MAC_W'({$urandom(), $urandom()});
    endfunction

    // offer one command word and wait until it is taken
    task automatic send_word(input cmd_t cmd, input logic [MAC_W-1:0] src,
                             input logic [MAC_W-1:0] dst, input logic [PORT_W-1:0] in_port,
                             input logic [MAC_W-1:0] target);
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, target, in_port, dst, src};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // random sender idle before the next word
    task automatic sender_gap();
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
    endtask

    // stop offering and let every pending decision arrive
    task automatic drain_decisions();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (table_model.pending() != 0)
            @(posedge clk);
    endtask

    // one random word, mostly frames over the shared address pool
    task automatic send_random_word();
        int               pick;
        logic [MAC_W-1:0] src;
        logic [MAC_W-1:0] dst;
        logic [MAC_W-1:0] target;
        pick   = $urandom_range(0, 999);
        src    = rand_mac();
        dst    = rand_mac();
        target = rand_mac();
        if (pick < 5)
            send_word(CMD_CLEAR, src, dst, PORT_W'($urandom()), target);
        else if (pick < 15)
            send_word(CMD_RSVD, src, dst, PORT_W'($urandom()), target);
        else if (pick < 95)
        begin
            if ($urandom_range(0, 99) < 80)
                target = mac_pool[$urandom_range(0, POOL_SIZE - 1)];
            send_word(CMD_DELETE, src, dst, PORT_W'($urandom()), target);
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 85)
                src = mac_pool[$urandom_range(0, POOL_SIZE - 1)];
            else if (pick < 90)
                src = ($urandom_range(0, 1) != 0) ? MAC_BCAST : '0;
            pick = $urandom_range(0, 99);
            if (pick < 60)
                dst = mac_pool[$urandom_range(0, POOL_SIZE - 1)];
            else if (pick < 75)
                dst = MAC_BCAST;
            send_word(CMD_FRAME, src, dst, PORT_W'($urandom()), target);
        end
    endtask

    // main sequence
    initial
    begin
        logic [MAC_W-1:0] mac_a;
        logic [MAC_W-1:0] mac_b;
        logic [MAC_W-1:0] mac_c;
        logic [MAC_W-1:0] mac_e;
        rst_n          <= 1'b0;
        s_tvalid       <= 1'b0;
        s_tdata        <= '0;
        s_tuser        <= '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        mac_a          = 48'h02_00_5e_10_20_30;
        mac_b          = 48'haa_aa_aa_aa_aa_aa;
        mac_c          = 48'h55_55_55_55_55_55;
        mac_e          = 48'h02_00_5e_10_20_31;

        // half the pool differs from the other half in a single bit
        for (int i = 0; i < POOL_SIZE / 2; i++)
        begin
            mac_pool[i]                 = rand_mac();
            mac_pool[i + POOL_SIZE / 2] = mac_pool[i] ^ (48'd1 << $urandom_range(0, MAC_W - 1));
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, learning, forwarding and maintenance
        send_word(CMD_FRAME, '0, MAC_BCAST, 4'd0, '0);
        send_word(CMD_FRAME, MAC_BCAST, '0, 4'd15, MAC_BCAST);
        send_word(CMD_FRAME, mac_a, mac_a, 4'd7, mac_b);
        send_word(CMD_FRAME, mac_a, MAC_BCAST, 4'd3, mac_c);
        send_word(CMD_FRAME, mac_b, mac_a, 4'd9, '0);
        send_word(CMD_FRAME, mac_c, mac_e, 4'd10, MAC_BCAST);
        send_word(CMD_FRAME, mac_e, mac_b, 4'd5, mac_a);
        send_word(CMD_DELETE, mac_b, mac_c, 4'd15, mac_a);
        send_word(CMD_DELETE, '0, MAC_BCAST, 4'd0, mac_a);
        send_word(CMD_FRAME, mac_a ^ 48'h8000_0000_0000, mac_a, 4'd12, mac_e);
        send_word(CMD_FRAME, mac_c, mac_e, 4'd1, mac_b);
        send_word(CMD_RSVD, MAC_BCAST, MAC_BCAST, 4'd15, MAC_BCAST);
        send_word(CMD_CLEAR, mac_c, mac_b, 4'd6, mac_e);
        send_word(CMD_FRAME, mac_b, mac_b, 4'd2, '0);
        send_word(CMD_DELETE, mac_c, mac_a, 4'd4, MAC_BCAST);
        send_word(CMD_FRAME, mac_c, '0, 4'd8, mac_c);

        // random phases: none, sender idle, receiver stall, both
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                // long receiver hold-off while words keep coming
                if (phase == 0 && n == 20)
                    hold_req = 1'b1;
                // sender waits for the block to go quiet
                if (phase == 3 && n == 200)
                    drain_decisions();
                sender_gap();
                send_random_word();
            end
        end

        // wait for the last decisions, then a little longer
        drain_decisions();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (table_model.mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
